FILE: rtl/wsscm_pkg.sv
// shared types, constants and codes of the working-set slot cache manager
package wsscm_pkg;

    localparam int ID_DEPTH   = 1024;
    localparam int ID_W       = 10;
    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = 4;
    localparam int LIST_DEPTH = 16;
    localparam int LIST_W     = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int FCNT_W     = $clog2(SLOT_COUNT + 1);
    localparam int ECNT_W     = 11;
    localparam logic [ECNT_W-1:0] ENTRY_COUNT_RST = ECNT_W'(1024);

    typedef enum logic [1:0] {
        FUNC_FETCH = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_FLUSH = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        KIND_WB      = 3'd0,
        KIND_READ_IN = 3'd1,
        KIND_HIT     = 3'd2,
        KIND_MISS    = 3'd3,
        KIND_DONE    = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ERR_OK         = 3'd0,
        ERR_INVALID_ID = 3'd1,
        ERR_FETCH_FULL = 3'd2,
        ERR_NO_SLOT    = 3'd3,
        ERR_CUR_FULL   = 3'd4
    } t_err;

    typedef struct packed {
        t_func            func;
        logic [ID_W-1:0]  row_id;
        logic             batch_last;
    } t_in_req;

    typedef struct packed {
        t_kind             kind;
        logic [ID_W-1:0]   out_id;
        logic [SLOT_W-1:0] out_slot;
        t_err              error_code;
        logic              last_result;
    } t_out_req;

    // status word of one id
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              fetch_mark;
        logic              to_remove;
        logic              dirty;
        logic              in_memory;
    } t_status;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR_INIT,
        OP_CLR_STEP,
        OP_ACCEPT,
        OP_LOOKUP,
        OP_SKIP,
        OP_FETCH,
        OP_FAIL,
        OP_RD_REM,
        OP_RD_CUR,
        OP_EVICT,
        OP_PH2,
        OP_SPLIT,
        OP_PH3,
        OP_ALLOC,
        OP_DONE
    } t_op;

    // flush emit steps reuse the scan ops with a flag
    typedef struct packed {
        t_op  op;
        t_err err;
        logic fl_emit;
        logic fl_step;
    } t_cmd;

    typedef struct packed {
        t_func   func;
        logic    last;
        logic    id_ok;
        logic    abort;
        t_status st;
        logic    cur_full;
        logic    pend_full;
        logic    free_empty;
        logic    i_lt_rem;
        logic    i_lt_cur;
        logic    i_lt_pend;
        logic    clr_last;
        logic    out_free;
    } t_dp_stat;

endpackage

FILE: rtl/wsscm_datapath.sv
// status store, id lists, free slot stack and result register
module wsscm_datapath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  wsscm_pkg::t_cmd         i_cmd,
    input  wsscm_pkg::t_in_req      i_in,
    input  logic                    i_cfg_we,
    input  logic [10:0]             i_cfg_wdata,
    input  logic                    i_out_stall,
    output wsscm_pkg::t_dp_stat     o_stat,
    output logic                    o_out_valid,
    output wsscm_pkg::t_out_req     o_out
);
    import wsscm_pkg::*;

    t_status             r_mem [ID_DEPTH];
    t_status             r_rdata;
    logic [ID_W-1:0]     r_addr;
    logic [ID_W-1:0]     r_cur  [LIST_DEPTH];
    logic [ID_W-1:0]     r_rem  [LIST_DEPTH];
    logic [ID_W-1:0]     r_pend [LIST_DEPTH];
    logic [SLOT_W-1:0]   r_stack [SLOT_COUNT];
    logic [CNT_W-1:0]    r_cur_cnt, r_rem_cnt, r_pend_cnt, r_i, r_kept;
    logic [FCNT_W-1:0]   r_free_cnt;
    logic                r_abort;
    logic [ID_W-1:0]     r_clr_addr;
    t_func               r_func;
    logic [ID_W-1:0]     r_id;
    logic                r_last;
    logic [ECNT_W-1:0]   r_entry_count;
    t_out_req            r_out;
    logic                r_out_valid;

    logic                mem_re, mem_we;
    logic [ID_W-1:0]     mem_raddr, mem_waddr;
    t_status             mem_wdata;
    logic                e_valid;
    t_out_req            e_out;
    logic                out_free, id_ok;
    logic [FCNT_W-1:0]   free_m1;
    logic [LIST_W-1:0]   idx;
    logic [SLOT_W-1:0]   pop_slot;

    assign idx      = r_i[LIST_W-1:0];
    assign free_m1  = r_free_cnt - 1'b1;
    assign pop_slot = r_stack[free_m1[SLOT_W-1:0]];
    assign out_free = !r_out_valid || !i_out_stall;
    assign id_ok    = {1'b0, r_id} < r_entry_count;

    // status store read and write controls
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = i_in.row_id;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = r_rdata;
        case (i_cmd.op)
            OP_ACCEPT: begin
                mem_re = 1'b1;
            end
            OP_RD_REM: begin
                mem_re    = 1'b1;
                mem_raddr = r_rem[idx];
            end
            OP_RD_CUR: begin
                mem_re    = 1'b1;
                mem_raddr = r_cur[idx];
            end
            OP_CLR_STEP: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            OP_LOOKUP: begin
                mem_we          = (r_func == FUNC_WRITE) && id_ok && r_rdata.in_memory;
                mem_wdata.dirty = 1'b1;
            end
            OP_FETCH: begin
                mem_we               = !r_rdata.fetch_mark;
                mem_wdata.fetch_mark = 1'b1;
                if (r_rdata.in_memory) begin
                    mem_wdata.to_remove = 1'b0;
                end
            end
            OP_EVICT: begin
                mem_we    = r_rdata.to_remove && !i_cmd.fl_step;
                mem_wdata = '0;
            end
            OP_SPLIT: begin
                mem_we = 1'b1;
                if (r_rdata.fetch_mark) begin
                    mem_wdata.fetch_mark = 1'b0;
                end else begin
                    mem_wdata.to_remove = 1'b1;
                end
            end
            OP_ALLOC: begin
                mem_we    = 1'b1;
                mem_waddr = r_pend[idx];
                mem_wdata = '{slot: pop_slot, fetch_mark: 1'b0, to_remove: 1'b0,
                              dirty: 1'b0, in_memory: 1'b1};
            end
            default: begin
            end
        endcase
    end

    // status store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
            r_addr  <= mem_raddr;
        end
    end

    // result to emit
    always_comb begin
        e_valid = 1'b0;
        e_out   = '{kind: KIND_DONE, out_id: r_id, out_slot: '0,
                    error_code: i_cmd.err, last_result: 1'b1};
        case (i_cmd.op)
            OP_LOOKUP: begin
                e_valid = 1'b1;
                e_out.error_code = ERR_OK;
                if (!id_ok) begin
                    e_out.kind       = KIND_MISS;
                    e_out.error_code = ERR_INVALID_ID;
                end else if (r_rdata.in_memory) begin
                    e_out.kind     = KIND_HIT;
                    e_out.out_slot = r_rdata.slot;
                end else begin
                    e_out.kind = KIND_MISS;
                end
            end
            OP_FAIL, OP_DONE: begin
                e_valid = 1'b1;
            end
            OP_EVICT, OP_SPLIT: begin
                e_valid = i_cmd.fl_emit;
                e_out   = '{kind: KIND_WB, out_id: r_addr, out_slot: r_rdata.slot,
                            error_code: ERR_OK, last_result: 1'b0};
            end
            OP_ALLOC: begin
                e_valid = 1'b1;
                e_out   = '{kind: KIND_READ_IN, out_id: r_pend[idx], out_slot: pop_slot,
                            error_code: ERR_OK, last_result: 1'b0};
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (e_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (e_valid) begin
            r_out <= e_out;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= ENTRY_COUNT_RST;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_wdata;
        end
    end

    // lists, counters and free slot stack
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_cnt  <= '0;
            r_rem_cnt  <= '0;
            r_pend_cnt <= '0;
            r_free_cnt <= FCNT_W'(SLOT_COUNT);
            r_abort    <= 1'b0;
            r_i        <= '0;
            r_kept     <= '0;
            r_clr_addr <= '0;
        end else begin
            case (i_cmd.op)
                OP_CLR_INIT: begin
                    r_cur_cnt  <= '0;
                    r_rem_cnt  <= '0;
                    r_pend_cnt <= '0;
                    r_free_cnt <= FCNT_W'(SLOT_COUNT);
                    r_abort    <= 1'b0;
                    r_clr_addr <= '0;
                    for (int k = 0; k < SLOT_COUNT; k++) begin
                        r_stack[k] <= SLOT_W'(k);
                    end
                end
                OP_CLR_STEP: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
                OP_ACCEPT: begin
                    r_func <= i_in.func;
                    r_id   <= i_in.row_id;
                    r_last <= i_in.batch_last;
                    r_i    <= '0;
                end
                OP_SKIP: begin
                    if (r_last) begin
                        r_abort <= 1'b0;
                    end
                end
                OP_FETCH: begin
                    if (!r_rdata.fetch_mark) begin
                        if (r_rdata.in_memory) begin
                            if (r_rdata.to_remove) begin
                                r_cur[r_cur_cnt[LIST_W-1:0]] <= r_id;
                                r_cur_cnt <= r_cur_cnt + 1'b1;
                            end
                        end else begin
                            r_pend[r_pend_cnt[LIST_W-1:0]] <= r_id;
                            r_pend_cnt <= r_pend_cnt + 1'b1;
                        end
                    end
                end
                OP_FAIL: begin
                    r_pend_cnt <= '0;
                    r_abort    <= !r_last;
                end
                OP_EVICT: begin
                    r_i <= r_i + 1'b1;
                    if (r_rdata.to_remove && !i_cmd.fl_step &&
                        r_free_cnt < FCNT_W'(SLOT_COUNT)) begin
                        r_stack[r_free_cnt[SLOT_W-1:0]] <= r_rdata.slot;
                        r_free_cnt <= r_free_cnt + 1'b1;
                    end
                end
                OP_PH2: begin
                    r_i       <= '0;
                    r_kept    <= '0;
                    r_rem_cnt <= '0;
                end
                OP_SPLIT: begin
                    r_i <= r_i + 1'b1;
                    if (!i_cmd.fl_step) begin
                        if (r_rdata.fetch_mark) begin
                            r_cur[r_kept[LIST_W-1:0]] <= r_addr;
                            r_kept <= r_kept + 1'b1;
                        end else begin
                            r_rem[r_rem_cnt[LIST_W-1:0]] <= r_addr;
                            r_rem_cnt <= r_rem_cnt + 1'b1;
                        end
                    end
                end
                OP_PH3: begin
                    r_i       <= '0;
                    r_cur_cnt <= i_cmd.fl_step ? r_cur_cnt : r_kept;
                end
                OP_ALLOC: begin
                    r_free_cnt <= free_m1;
                    r_cur[r_cur_cnt[LIST_W-1:0]] <= r_pend[idx];
                    r_cur_cnt <= r_cur_cnt + 1'b1;
                    r_i <= r_i + 1'b1;
                end
                OP_DONE: begin
                    r_pend_cnt <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stat = '{
        func:       r_func,
        last:       r_last,
        id_ok:      id_ok,
        abort:      r_abort,
        st:         r_rdata,
        cur_full:   r_cur_cnt == CNT_W'(LIST_DEPTH),
        pend_full:  r_pend_cnt == CNT_W'(LIST_DEPTH),
        free_empty: r_free_cnt == '0,
        i_lt_rem:   r_i < r_rem_cnt,
        i_lt_cur:   r_i < r_cur_cnt,
        i_lt_pend:  r_i < r_pend_cnt,
        clr_last:   r_clr_addr == ID_W'(ID_DEPTH - 1),
        out_free:   out_free
    };

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: rtl/wsscm_ctrl.sv
// sequencer for requests, batch end walks, flush and clearing pass
module wsscm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  wsscm_pkg::t_dp_stat i_stat,
    output wsscm_pkg::t_cmd     o_cmd
);
    import wsscm_pkg::*;

    typedef enum logic [13:0] {
        S_CLR_INIT = 14'h0001,
        S_CLEAR    = 14'h0002,
        S_IDLE     = 14'h0004,
        S_EVAL     = 14'h0008,
        S_EV_RD    = 14'h0010,
        S_EV_CHK   = 14'h0020,
        S_SP_RD    = 14'h0040,
        S_SP_CHK   = 14'h0080,
        S_ALLOC    = 14'h0100,
        S_DONE     = 14'h0200,
        S_FL_RD    = 14'h0400,
        S_FL_CHK   = 14'h0800,
        S_FC_RD    = 14'h1000,
        S_FC_CHK   = 14'h2000
    } t_state;

    t_state r_state, n_state;
    logic   r_flush, n_flush;
    logic   need;

    assign o_in_stall = (r_state != S_IDLE);

    // next state and command
    always_comb begin
        n_state = r_state;
        n_flush = r_flush;
        o_cmd   = '{op: OP_NONE, err: ERR_OK, fl_emit: 1'b0, fl_step: 1'b0};
        need    = 1'b0;
        unique case (r_state)
            S_CLR_INIT: begin
                o_cmd.op = OP_CLR_INIT;
                n_state  = S_CLEAR;
            end
            S_CLEAR: begin
                o_cmd.op = OP_CLR_STEP;
                if (i_stat.clr_last) begin
                    n_state = r_flush ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_ACCEPT;
                    n_state  = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_stat.func == FUNC_FLUSH) begin
                    n_state = S_FL_RD;
                end else if (i_stat.func != FUNC_FETCH) begin
                    if (i_stat.out_free) begin
                        o_cmd.op = OP_LOOKUP;
                        n_state  = S_IDLE;
                    end
                end else if (i_stat.abort) begin
                    o_cmd.op = OP_SKIP;
                    n_state  = S_IDLE;
                end else if (!i_stat.id_ok) begin
                    if (i_stat.out_free) begin
                        o_cmd.op  = OP_FAIL;
                        o_cmd.err = ERR_INVALID_ID;
                        n_state   = S_IDLE;
                    end
                end else if (!i_stat.st.fetch_mark && i_stat.st.in_memory &&
                             i_stat.st.to_remove && i_stat.cur_full) begin
                    if (i_stat.out_free) begin
                        o_cmd.op  = OP_FAIL;
                        o_cmd.err = ERR_CUR_FULL;
                        n_state   = S_IDLE;
                    end
                end else if (!i_stat.st.fetch_mark && !i_stat.st.in_memory &&
                             i_stat.pend_full) begin
                    if (i_stat.out_free) begin
                        o_cmd.op  = OP_FAIL;
                        o_cmd.err = ERR_FETCH_FULL;
                        n_state   = S_IDLE;
                    end
                end else begin
                    o_cmd.op = OP_FETCH;
                    n_state  = i_stat.last ? S_EV_RD : S_IDLE;
                end
            end
            // evict rows still marked for removal
            S_EV_RD: begin
                if (i_stat.i_lt_rem) begin
                    o_cmd.op = OP_RD_REM;
                    n_state  = S_EV_CHK;
                end else begin
                    o_cmd.op = OP_PH2;
                    n_state  = S_SP_RD;
                end
            end
            S_EV_CHK: begin
                need = i_stat.st.to_remove && i_stat.st.dirty;
                if (!need || i_stat.out_free) begin
                    o_cmd.op      = OP_EVICT;
                    o_cmd.fl_emit = need;
                    n_state       = S_EV_RD;
                end
            end
            // split current ids into kept and next removal list
            S_SP_RD: begin
                if (i_stat.i_lt_cur) begin
                    o_cmd.op = OP_RD_CUR;
                    n_state  = S_SP_CHK;
                end else begin
                    o_cmd.op = OP_PH3;
                    n_state  = S_ALLOC;
                end
            end
            S_SP_CHK: begin
                o_cmd.op = OP_SPLIT;
                n_state  = S_SP_RD;
            end
            // slot allocation for new ids
            S_ALLOC: begin
                if (!i_stat.i_lt_pend) begin
                    n_state = S_DONE;
                end else if (i_stat.out_free) begin
                    if (i_stat.free_empty) begin
                        o_cmd.op  = OP_FAIL;
                        o_cmd.err = ERR_NO_SLOT;
                        n_state   = S_IDLE;
                    end else if (i_stat.cur_full) begin
                        o_cmd.op  = OP_FAIL;
                        o_cmd.err = ERR_CUR_FULL;
                        n_state   = S_IDLE;
                    end else begin
                        o_cmd.op = OP_ALLOC;
                    end
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_DONE;
                    n_flush  = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            // flush: write back dirty removal ids, then dirty current ids
            S_FL_RD: begin
                if (i_stat.i_lt_rem) begin
                    o_cmd.op = OP_RD_REM;
                    n_state  = S_FL_CHK;
                end else begin
                    o_cmd.op      = OP_PH3;
                    o_cmd.fl_step = 1'b1;
                    n_state       = S_FC_RD;
                end
            end
            S_FL_CHK: begin
                need = i_stat.st.to_remove && i_stat.st.dirty;
                if (!need || i_stat.out_free) begin
                    o_cmd.op      = OP_EVICT;
                    o_cmd.fl_emit = need;
                    o_cmd.fl_step = 1'b1;
                    n_state       = S_FL_RD;
                end
            end
            S_FC_RD: begin
                if (i_stat.i_lt_cur) begin
                    o_cmd.op = OP_RD_CUR;
                    n_state  = S_FC_CHK;
                end else begin
                    n_flush = 1'b1;
                    n_state = S_CLR_INIT;
                end
            end
            S_FC_CHK: begin
                need = i_stat.st.dirty;
                if (!need || i_stat.out_free) begin
                    o_cmd.op      = OP_SPLIT;
                    o_cmd.fl_emit = need;
                    o_cmd.fl_step = 1'b1;
                    n_state       = S_FC_RD;
                end
            end
            default: begin
                n_state = S_CLR_INIT;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR_INIT;
            r_flush <= 1'b0;
        end else begin
            r_state <= n_state;
            r_flush <= n_flush;
        end
    end

endmodule

FILE: rtl/working_set_slot_cache_manager.sv
// top level of the working-set slot cache manager
// A request is taken only while the block is idle. A lookup or a fetch batch
// element reads the status store, then updates it, answers, or both; the last
// element of a batch then walks the removal-list ids and the current ids and
// allocates slots to the new ids, with phase changes between the walks, and
// ends with a done result. A flush walks the removal-list and current ids,
// then runs a clearing pass over the status store, then gives its done result;
// the same pass runs after reset, and no request is taken until it ends. Any
// cycle that has a result to hand over waits while the output register is
// stalled.
module working_set_slot_cache_manager (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  wsscm_pkg::t_in_req    i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output wsscm_pkg::t_out_req   o_out,
    input  logic                  i_cfg_we,
    input  logic [10:0]           i_cfg_wdata
);
    import wsscm_pkg::*;

    t_cmd     cmd;
    t_dp_stat stat;

    // sequencer
    wsscm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // storage and result path
    wsscm_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule
